>>> rtl/core/dgm_pkg.sv
// Shared types and constants for the decimal digit glyph emitter.
package dgm_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_GLYPH_BASE      = 2'd0;
	localparam logic [1:0] REG_DIGIT_WIDTH     = 2'd1;
	localparam logic [1:0] REG_SEPARATOR_WIDTH = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int BASE_W  = 16;
	localparam int GLYPH_W = 17;
	localparam int WIDTH_W = 10;
	localparam int X_W     = 20;
	localparam int FRAC_W  = 4;

	localparam logic [BASE_W-1:0]  GLYPH_BASE_RST      = 16'd0;
	localparam logic [WIDTH_W-1:0] DIGIT_WIDTH_RST     = 10'd8;
	localparam logic [WIDTH_W-1:0] SEPARATOR_WIDTH_RST = 10'd4;

	// Separator glyph sits ten above digit zero
	localparam logic [GLYPH_W-1:0] SEP_OFFSET = 17'd10;

	// Digits per thousands group, minus one (group counter wraps here)
	localparam logic [1:0] GROUP_LAST = 2'd2;

	typedef logic [3:0] digit_t;

endpackage

>>> rtl/core/dgm_div10.sv
// Shared divide-by-ten unit: reciprocal multiply plus digit recovery.
module dgm_div10 import dgm_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic [VALUE_BITS-1:0] num,
	output logic [VALUE_BITS-1:0] quot,
	output logic [VALUE_BITS+2:0] frac,
	input  logic [VALUE_BITS+2:0] frac_in,
	output digit_t                digit
);

	localparam int SHIFT = VALUE_BITS + 3;
	localparam int PROD_W = VALUE_BITS + SHIFT + 1;
	localparam logic [SHIFT:0] TWO_S = {1'b1, {SHIFT{1'b0}}};
	localparam logic [SHIFT:0] TEN = (SHIFT+1)'(10);
	localparam logic [SHIFT:0] ONE = (SHIFT+1)'(1);
	// ceil-style reciprocal of ten; error term stays within 2^(SHIFT-VALUE_BITS)
	localparam logic [SHIFT:0] RECIP = TWO_S / TEN + ONE;

	logic [PROD_W-1:0] prod;
	logic [SHIFT+3:0]  frac_x10;

	assign prod = {{(SHIFT+1){1'b0}}, num} * {{VALUE_BITS{1'b0}}, RECIP};
	assign quot = prod[SHIFT +: VALUE_BITS];
	assign frac = prod[SHIFT-1:0];

	// Remainder digit is the integer part of fraction times ten
	assign frac_x10 = {1'b0, frac_in, 3'b000} + {3'b000, frac_in, 1'b0};
	assign digit = frac_x10[SHIFT+3:SHIFT];

endmodule

>>> rtl/core/decimal_digits_with_group_marks.sv
// Top level: binary to decimal glyph run with thousands separators.
//
// Takes an unsigned number and the x of its rightmost digit, then emits one
// output word per glyph, right to left: least significant digit first, with a
// separator glyph after every third digit when more digits follow. Digit glyphs
// are glyph_base + digit, the separator is glyph_base + 10, and last marks the
// final digit. x is signed 16.4 fixed point and wraps in 20 bits; each digit
// step moves left by digit_width pixels, a separator by separator_width pixels.
// Each item is taken in the idle state, runs its first divide in S_DIV, then
// emits one output word per cycle in S_RUN while the output is not stalled.
// Digits come from the shared divide-by-ten unit (a reciprocal multiply whose
// quotient feeds back into itself once per digit). in_stall is high while an
// item is in progress. Configuration writes are always taken (cfg_ready is
// tied high) and must only be issued while the block is idle; unknown indexes
// are dropped.
module decimal_digits_with_group_marks import dgm_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [VALUE_BITS-1:0]      value,
	input  logic signed [X_W-1:0]      x_start,
	// Output channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [GLYPH_W-1:0]  glyph_index,
	output logic signed [X_W-1:0]      x_pos,
	output logic                       is_separator,
	output logic                       last,
	// Configuration channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	localparam int DIV_FRAC_W = VALUE_BITS + 3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_RUN
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [BASE_W-1:0]  glyph_base_q;
	logic [WIDTH_W-1:0] digit_width_q;
	logic [WIDTH_W-1:0] separator_width_q;

	// Working registers
	logic [VALUE_BITS-1:0]  num_q;
	logic [DIV_FRAC_W-1:0]  frac_q;
	logic [X_W-1:0]         x_q;
	logic [1:0]             count_q;
	logic                   sep_pend_q;

	// Output word register
	logic                   out_valid_q;
	logic [GLYPH_W-1:0]     glyph_q;
	logic [X_W-1:0]         x_pos_q;
	logic                   sep_q;
	logic                   last_q;

	logic [VALUE_BITS-1:0]  quot;
	logic [DIV_FRAC_W-1:0]  frac;
	digit_t                 digit;

	logic                   in_fire;
	logic                   slot_free;
	logic                   num_zero;
	logic [GLYPH_W-1:0]     base_ext;
	logic [X_W-1:0]         dstep;
	logic [X_W-1:0]         sstep;

	dgm_div10 #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.num     (num_q),
		.quot    (quot),
		.frac    (frac),
		.frac_in (frac_q),
		.digit   (digit)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Output slot can take a new word when empty or being drained this cycle
	assign slot_free = !out_valid_q || !out_stall;
	// num_q holds the quotient left after the digit now in frac_q
	assign num_zero  = (num_q == '0);

	assign base_ext = {glyph_base_q[BASE_W-1], glyph_base_q};
	assign dstep    = {{(X_W-WIDTH_W-FRAC_W){1'b0}}, digit_width_q, {FRAC_W{1'b0}}};
	assign sstep    = {{(X_W-WIDTH_W-FRAC_W){1'b0}}, separator_width_q, {FRAC_W{1'b0}}};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_base_q      <= GLYPH_BASE_RST;
			digit_width_q     <= DIGIT_WIDTH_RST;
			separator_width_q <= SEPARATOR_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GLYPH_BASE:      glyph_base_q      <= cfg_data;
				REG_DIGIT_WIDTH:     digit_width_q     <= cfg_data[WIDTH_W-1:0];
				REG_SEPARATOR_WIDTH: separator_width_q <= cfg_data[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, working state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sep_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
			num_q       <= '0;
			frac_q      <= '0;
			x_q         <= '0;
			glyph_q     <= '0;
			x_pos_q     <= '0;
			sep_q       <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			// Drop the held word once taken; while running, the next word replaces it
			if (out_valid_q && !out_stall && (state_q != S_RUN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						num_q      <= value;
						x_q        <= x_start;
						count_q    <= '0;
						sep_pend_q <= 1'b0;
						state_q    <= S_DIV;
					end
				end
				S_DIV: begin
					// First divide: peel the least significant digit
					num_q   <= quot;
					frac_q  <= frac;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						x_pos_q     <= x_q;
						if (sep_pend_q) begin
							glyph_q    <= base_ext + SEP_OFFSET;
							sep_q      <= 1'b1;
							last_q     <= 1'b0;
							sep_pend_q <= 1'b0;
							x_q        <= x_q - dstep;
						end else begin
							glyph_q <= base_ext + {{(GLYPH_W-4){1'b0}}, digit};
							sep_q   <= 1'b0;
							last_q  <= num_zero;
							// Advance the shared divider for the next digit
							num_q   <= quot;
							frac_q  <= frac;
							if (count_q == GROUP_LAST) begin
								count_q <= '0;
								if (!num_zero) begin
									sep_pend_q <= 1'b1;
									x_q        <= x_q - sstep;
								end else begin
									x_q <= x_q - dstep;
								end
							end else begin
								count_q <= count_q + 2'd1;
								x_q     <= x_q - dstep;
							end
							if (num_zero) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign glyph_index  = glyph_q;
	assign x_pos        = x_pos_q;
	assign is_separator = sep_q;
	assign last         = last_q;

	// A separator is only ever placed ahead of more digits
	a_sep_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && sep_q |-> !last_q)
		else $error("separator word flagged as last");

	// A pending separator always follows a completed group of three
	a_sep_after_group: assert property (@(posedge clk) disable iff (!arst_n)
		sep_pend_q |-> (state_q == S_RUN) && (count_q == '0))
		else $error("separator pending outside a completed group");

	// Every accepted word starts with the first divide
	a_accept_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_DIV))
		else $error("accepted word did not start a divide");

endmodule

>>> tb/sv/tb_decimal_digits_with_group_marks.sv
// Self-checking testbench for the decimal digit glyph emitter with thousands marks.
`timescale 1ns / 100ps

module tb_decimal_digits_with_group_marks;
	import dgm_pkg::*;

	// Index that decodes to no register; a write to it must be dropped
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	localparam int DIGITS_PER_GROUP = 3;
	// Generous bound: ~235 items of up to 13 words under random receiver stall,
	// plus sender gaps, the long hold-off and every drain pause
	localparam int CYCLE_LIMIT = 200000;
	// Quiet cycles after the last word, well past the time one item takes
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		logic [GLYPH_W-1:0] glyph;
		logic [X_W-1:0]     x;
		logic               sep;
		logic               fin;
	} glyph_word_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [31:0]            value = '0;
	logic signed [X_W-1:0]  x_start = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [GLYPH_W-1:0] glyph_index;
	logic signed [X_W-1:0]  x_pos;
	logic                   is_separator;
	logic                   last;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Register shadow, kept in step with every accepted config write
	logic [BASE_W-1:0]  cur_glyph_base = GLYPH_BASE_RST;
	logic [WIDTH_W-1:0] cur_digit_width = DIGIT_WIDTH_RST;
	logic [WIDTH_W-1:0] cur_sep_width = SEPARATOR_WIDTH_RST;

	glyph_word_t pending_glyphs[$];
	glyph_word_t want;
	int          mismatch_count = 0;
	int          cycle_count = 0;

	// Receiver behavior, steered by the test tasks
	bit rx_stall_on = 1'b0;
	int hold_off_left = 0;
	bit rx_busy = 1'b0;
	int rx_run = 0;

	decimal_digits_with_group_marks u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.x_start      (x_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.glyph_index  (glyph_index),
		.x_pos        (x_pos),
		.is_separator (is_separator),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// Work out the glyph run for one number: digits right to left, a mark after
	// every third digit while digits remain; x wraps in 20 bits.
	task automatic predict_glyph_run(input logic [31:0] number, input logic [X_W-1:0] x_in);
		logic [31:0]        rest;
		logic [X_W-1:0]     x;
		logic [X_W-1:0]     digit_step;
		logic [X_W-1:0]     mark_step;
		logic [GLYPH_W-1:0] base;
		glyph_word_t        w;
		int                 group;
		rest = number;
		x = x_in;
		base = {cur_glyph_base[BASE_W-1], cur_glyph_base};
		digit_step = {{(X_W-WIDTH_W-FRAC_W){1'b0}}, cur_digit_width, {FRAC_W{1'b0}}};
		mark_step = {{(X_W-WIDTH_W-FRAC_W){1'b0}}, cur_sep_width, {FRAC_W{1'b0}}};
		group = 0;
		do begin
			w.glyph = base + GLYPH_W'(rest % 10);
			rest = rest / 10;
			w.x = x;
			w.sep = 1'b0;
			w.fin = (rest == 0);
			pending_glyphs.push_back(w);
			group++;
			if (group == DIGITS_PER_GROUP) begin
				group = 0;
				// Mark goes in only when more digits follow
				if (rest != 0) begin
					x = x - mark_step;
					w.glyph = base + SEP_OFFSET;
					w.x = x;
					w.sep = 1'b1;
					w.fin = 1'b0;
					pending_glyphs.push_back(w);
				end
			end
			x = x - digit_step;
		end while (rest != 0);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] wanted);
		$display("[%0t] glyph check failed on %s: got 0x%0h, wanted 0x%0h",
			$realtime, what, got, wanted);
		mismatch_count++;
	endtask

	// Compare every word taken from the output against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_glyphs.size() == 0) begin
				report_mismatch("unexpected word", 32'($unsigned(glyph_index)), '0);
			end else begin
				want = pending_glyphs.pop_front();
				if (glyph_index !== want.glyph)
					report_mismatch("glyph_index", 32'($unsigned(glyph_index)),
						32'(want.glyph));
				if (x_pos !== want.x)
					report_mismatch("x_pos", 32'($unsigned(x_pos)), 32'(want.x));
				if (is_separator !== want.sep)
					report_mismatch("is_separator", 32'(is_separator), 32'(want.sep));
				if (last !== want.fin)
					report_mismatch("last", 32'(last), 32'(want.fin));
			end
		end
	end

	// Receiver: hold off for a counted stretch when asked, otherwise stall in
	// alternating runs of random length, or never when stalling is off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				hold_off_left--;
				out_stall <= 1'b1;
			end else if (!rx_stall_on) begin
				out_stall <= 1'b0;
			end else begin
				if (rx_run == 0) begin
					rx_busy = !rx_busy;
					rx_run = rx_busy ? $urandom_range(1, 4) : $urandom_range(1, 6);
				end
				rx_run--;
				out_stall <= rx_busy;
			end
		end
	end

	// Offer one number and hold it until the block takes the word
	task automatic send_number(input logic [31:0] number, input logic [X_W-1:0] x_in);
		@(negedge clk);
		in_valid <= 1'b1;
		value <= number;
		x_start <= x_in;
		do @(posedge clk); while (in_stall);
		predict_glyph_run(number, x_in);
	endtask

	// Drop valid for a number of cycles
	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Wait until every expected word has arrived, then let the block settle
	task automatic drain_glyphs();
		idle_sender(1);
		while (pending_glyphs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; the caller drops cfg_valid after its last write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GLYPH_BASE:      cur_glyph_base = data;
			REG_DIGIT_WIDTH:     cur_digit_width = data[WIDTH_W-1:0];
			REG_SEPARATOR_WIDTH: cur_sep_width = data[WIDTH_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] base, input logic [CFG_DATA_W-1:0] dw,
		input logic [CFG_DATA_W-1:0] sw);
		drain_glyphs();
		write_reg(REG_GLYPH_BASE, base);
		write_reg(REG_DIGIT_WIDTH, dw);
		write_reg(REG_SEPARATOR_WIDTH, sw);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Spread digit counts evenly; all-zero and all-ones turn up often
	function automatic logic [31:0] pick_number();
		int                  digits;
		longint unsigned     span;
		digits = $urandom_range(0, 13);
		if (digits == 0)
			return '0;
		if (digits == 1)
			return '1;
		if (digits > 10)
			return $urandom;
		span = 1;
		repeat (digits) span = span * 10;
		return 32'($urandom % span);
	endfunction

	// Extremes of the number at the reset register values
	task automatic test_reset_defaults();
		send_number(32'd0, 20'sd0);
		send_number(32'd1, 20'sd160);
		send_number(32'd9, 20'h7FFFF);
		send_number(32'd10, 20'h80000);
		send_number(32'd99, 20'h00010);
		send_number(32'd100, 20'h00040);
		send_number(32'd999, 20'h00100);
		send_number(32'd1000, 20'h00100);
		send_number(32'd1001, 20'h00020);
		send_number(32'd999999, 20'h12345);
		send_number(32'd1000000, 20'h00050);
		send_number(32'hFFFF_FFFF, 20'h80000);
		send_number(32'd1234567890, 20'h7FFFF);
	endtask

	// Register extremes, with unused upper data bits set, and a dropped write
	task automatic test_register_extremes();
		configure(16'h8000, 16'hFFFF, 16'hFC00);
		write_reg(REG_UNUSED, 16'hFFFF);
		@(negedge clk);
		cfg_valid <= 1'b0;
		send_number(32'hFFFF_FFFF, 20'h80000);
		send_number(32'h8000_0000, 20'h7FFFF);
		send_number(32'd0, 20'h00000);
		configure(16'h7FFF, 16'h0000, 16'h03FF);
		send_number(32'hFFFF_FFFF, 20'h00000);
		send_number(32'd1000000, 20'h80000);
		send_number(32'd5, 20'h7FFFF);
		configure(GLYPH_BASE_RST, CFG_DATA_W'(DIGIT_WIDTH_RST),
			CFG_DATA_W'(SEPARATOR_WIDTH_RST));
	endtask

	// Random numbers in bursts; each phase runs under its own register set
	task automatic test_random_phases();
		int burst;
		int gap_max;
		for (int phase = 0; phase < 4; phase++) begin
			configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
			// First phase runs flat out on both sides
			rx_stall_on = (phase != 0);
			gap_max = (phase == 0) ? 0 : 12;
			burst = $urandom_range(1, 8);
			for (int i = 0; i < 48; i++) begin
				send_number(pick_number(), X_W'($urandom));
				burst--;
				if (burst == 0) begin
					burst = $urandom_range(1, 8);
					idle_sender(int'($urandom_range(0, gap_max)));
				end
			end
		end
	endtask

	// Hold off the receiver long enough that the block stalls its input
	task automatic test_backpressure();
		drain_glyphs();
		rx_stall_on = 1'b1;
		@(negedge clk);
		hold_off_left = 400;
		for (int i = 0; i < 12; i++)
			send_number(pick_number(), X_W'($urandom));
		drain_glyphs();
	endtask

	// Pause the sender until everything is out, then carry on
	task automatic test_sender_pause();
		for (int i = 0; i < 3; i++)
			send_number(pick_number(), X_W'($urandom));
		drain_glyphs();
		for (int i = 0; i < 3; i++)
			send_number(pick_number(), X_W'($urandom));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_random_phases();
		test_backpressure();
		test_sender_pause();

		drain_glyphs();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
